>>> sv/psd_pkg.sv
package psd_pkg;

  localparam int CoordBits = 16;
  localparam int DistBits  = 25;

  typedef enum logic [1:0] {
    REG_START  = 2'd0,
    REG_END    = 2'd1,
    REG_INNER  = 2'd2,
    REG_DEGEN  = 2'd3
  } region_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
    logic signed [CoordBits-1:0] start_x;
    logic signed [CoordBits-1:0] start_y;
    logic signed [CoordBits-1:0] end_x;
    logic signed [CoordBits-1:0] end_y;
  } in_req_t;

  typedef struct packed {
    logic [DistBits-1:0] distance;
    logic [1:0]          region;
  } out_res_t;

endpackage

>>> sv/psd_isqrt.sv
// pipelined restoring square root, one result bit per stage
module psd_isqrt #(
  parameter int InBits  = 64,
  parameter int TagBits = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic [InBits-1:0]      in_rad,
  input  logic [TagBits-1:0]     in_tag,
  output logic                   out_vld,
  output logic [InBits/2-1:0]    out_root,
  output logic [TagBits-1:0]     out_tag
);
  localparam int Steps = InBits / 2;
  localparam int RemBits = Steps + 2;

  logic                vld_r  [Steps+1];
  logic [InBits-1:0]   rad_r  [Steps+1];
  logic [RemBits-1:0]  rem_r  [Steps+1];
  logic [Steps-1:0]    root_r [Steps+1];
  logic [TagBits-1:0]  tag_r  [Steps+1];

  always_comb begin
    vld_r[0]  = in_vld;
    rad_r[0]  = in_rad;
    rem_r[0]  = '0;
    root_r[0] = '0;
    tag_r[0]  = in_tag;
  end

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [RemBits-1:0] trial_nxt;
    logic [RemBits-1:0] cand_nxt;
    logic [RemBits-1:0] sh_nxt;
    logic v_r;
    logic [InBits-1:0]  d_r;
    logic [RemBits-1:0] m_r;
    logic [Steps-1:0]   q_r;
    logic [TagBits-1:0] t_r;
    always_comb begin
      sh_nxt    = {rem_r[s][RemBits-3:0], rad_r[s][InBits-1 -: 2]};
      cand_nxt  = {root_r[s], 2'b01};
      trial_nxt = sh_nxt - cand_nxt;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else begin
        v_r <= vld_r[s];
      end
      d_r <= rad_r[s] << 2;
      t_r <= tag_r[s];
      if (sh_nxt >= cand_nxt) begin
        m_r <= trial_nxt;
        q_r <= {root_r[s][Steps-2:0], 1'b1};
      end else begin
        m_r <= sh_nxt;
        q_r <= {root_r[s][Steps-2:0], 1'b0};
      end
    end
    always_comb begin
      vld_r[s+1]  = v_r;
      rad_r[s+1]  = d_r;
      rem_r[s+1]  = m_r;
      root_r[s+1] = q_r;
      tag_r[s+1]  = t_r;
    end
  end

  assign out_vld  = vld_r[Steps];
  assign out_root = root_r[Steps];
  assign out_tag  = tag_r[Steps];
endmodule

>>> sv/psd_div.sv
// pipelined restoring divider, one quotient bit per stage
module psd_div #(
  parameter int NumBits = 64,
  parameter int DenBits = 32,
  parameter int TagBits = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic [NumBits-1:0]   in_num,
  input  logic [DenBits-1:0]   in_den,
  input  logic [TagBits-1:0]   in_tag,
  output logic                 out_vld,
  output logic [NumBits-1:0]   out_quo,
  output logic [TagBits-1:0]   out_tag
);
  localparam int RemBits = DenBits + 1;

  logic                vld_r [NumBits+1];
  logic [NumBits-1:0]  num_r [NumBits+1];
  logic [DenBits-1:0]  den_r [NumBits+1];
  logic [RemBits-1:0]  rem_r [NumBits+1];
  logic [TagBits-1:0]  tag_r [NumBits+1];

  always_comb begin
    vld_r[0] = in_vld;
    num_r[0] = in_num;
    den_r[0] = in_den;
    rem_r[0] = '0;
    tag_r[0] = in_tag;
  end

  for (genvar s = 0; s < NumBits; s++) begin : g_step
    logic [RemBits-1:0] sh_nxt;
    logic [RemBits-1:0] dz_nxt;
    logic               v_r;
    logic [NumBits-1:0] n_r;
    logic [DenBits-1:0] d_r;
    logic [RemBits-1:0] m_r;
    logic [TagBits-1:0] t_r;
    always_comb begin
      sh_nxt = {rem_r[s][RemBits-2:0], num_r[s][NumBits-1]};
      dz_nxt = {1'b0, den_r[s]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else begin
        v_r <= vld_r[s];
      end
      d_r <= den_r[s];
      t_r <= tag_r[s];
      // numerator register doubles as the quotient shift register
      if (sh_nxt >= dz_nxt) begin
        m_r <= sh_nxt - dz_nxt;
        n_r <= {num_r[s][NumBits-2:0], 1'b1};
      end else begin
        m_r <= sh_nxt;
        n_r <= {num_r[s][NumBits-2:0], 1'b0};
      end
    end
    always_comb begin
      vld_r[s+1] = v_r;
      num_r[s+1] = n_r;
      den_r[s+1] = d_r;
      rem_r[s+1] = m_r;
      tag_r[s+1] = t_r;
    end
  end

  assign out_vld = vld_r[NumBits];
  assign out_quo = num_r[NumBits];
  assign out_tag = tag_r[NumBits];
endmodule

>>> sv/psd_geom.sv
// front end: differences, products, sums, region choice, radicand and absolute cross product
module psd_geom #(
  parameter int FracBits  = 8
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_vld,
  input  psd_pkg::in_req_t                            in_req,
  output logic                                        out_vld,
  output logic [2*psd_pkg::CoordBits+3+2*FracBits:0]  out_rad,
  output logic [2*psd_pkg::CoordBits+1:0]             out_cross,
  output logic [1:0]                                  out_region
);
  localparam int CoordBits = psd_pkg::CoordBits;
  localparam int DB = CoordBits + 1;
  localparam int PB = 2 * DB;
  localparam int SB = PB + 1;
  localparam int RB = 2 * CoordBits + 4 + 2 * FracBits;

  // stage 1: differences
  logic v1_r;
  logic signed [DB-1:0] x_r, y_r, ux_r, uy_r, fx_r, fy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= in_vld;
    x_r  <= DB'(in_req.point_x) - DB'(in_req.start_x);
    y_r  <= DB'(in_req.point_y) - DB'(in_req.start_y);
    ux_r <= DB'(in_req.end_x) - DB'(in_req.start_x);
    uy_r <= DB'(in_req.end_y) - DB'(in_req.start_y);
    fx_r <= DB'(in_req.point_x) - DB'(in_req.end_x);
    fy_r <= DB'(in_req.point_y) - DB'(in_req.end_y);
  end

  // stage 2: products
  logic v2_r;
  logic signed [PB-1:0] xux_r, yuy_r, uxux_r, uyuy_r, xuy_r, yux_r, xx_r, yy_r, ff1_r, ff2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    xux_r  <= PB'(x_r) * PB'(ux_r);
    yuy_r  <= PB'(y_r) * PB'(uy_r);
    uxux_r <= PB'(ux_r) * PB'(ux_r);
    uyuy_r <= PB'(uy_r) * PB'(uy_r);
    xuy_r  <= PB'(x_r) * PB'(uy_r);
    yux_r  <= PB'(y_r) * PB'(ux_r);
    xx_r   <= PB'(x_r) * PB'(x_r);
    yy_r   <= PB'(y_r) * PB'(y_r);
    ff1_r  <= PB'(fx_r) * PB'(fx_r);
    ff2_r  <= PB'(fy_r) * PB'(fy_r);
  end

  // stage 3: sums
  logic v3_r;
  logic signed [SB-1:0] dot_r, len2_r, crs_r, ds_r, de_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
    dot_r  <= SB'(xux_r) + SB'(yuy_r);
    len2_r <= SB'(uxux_r) + SB'(uyuy_r);
    crs_r  <= SB'(xuy_r) - SB'(yux_r);
    ds_r   <= SB'(xx_r) + SB'(yy_r);
    de_r   <= SB'(ff1_r) + SB'(ff2_r);
  end

  // stage 4: region and radicand selection, absolute cross product
  logic v4_r;
  logic [RB-1:0] rad_r;
  logic [SB-2:0] acr_r;
  logic [1:0] reg_r;
  logic [1:0] reg_nxt;
  logic [SB-1:0] sel_nxt;
  always_comb begin
    if (len2_r == '0) begin
      reg_nxt = psd_pkg::REG_DEGEN;
      sel_nxt = '0;
    end else if (dot_r <= 0) begin
      reg_nxt = psd_pkg::REG_START;
      sel_nxt = ds_r;
    end else if (dot_r >= len2_r) begin
      reg_nxt = psd_pkg::REG_END;
      sel_nxt = de_r;
    end else begin
      reg_nxt = psd_pkg::REG_INNER;
      sel_nxt = len2_r;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else v4_r <= v3_r;
    rad_r <= RB'(sel_nxt) << (2 * FracBits);
    acr_r <= crs_r[SB-1] ? (SB-1)'(-crs_r) : (SB-1)'(crs_r);
    reg_r <= reg_nxt;
  end

  assign out_vld    = v4_r;
  assign out_rad    = rad_r;
  assign out_cross  = acr_r;
  assign out_region = reg_r;
endmodule

>>> sv/point_segment_distance.sv
// channel   ports                       width / meaning
// request   start, busy, in_req         6 x 16-bit signed coordinates
// result    out_strobe, out_res         distance (FRAC_BITS fraction), region
//
// pipeline: 4 geometry stages, one root stage per bit of the root, one
// divider stage per numerator bit, then an output register; the same for
// every request. one request per cycle, busy is tied low.
// reset clears every stage valid bit; data registers are not reset.
// the receiver cannot stall, so nothing holds the pipe.
module point_segment_distance #(
  parameter int FRAC_BITS  = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  psd_pkg::in_req_t  in_req,
  output logic              out_strobe,
  output psd_pkg::out_res_t out_res
);
  localparam int COORD_BITS = psd_pkg::CoordBits;
  localparam int RB  = 2 * COORD_BITS + 4 + 2 * FRAC_BITS;
  localparam int QB  = RB / 2;
  localparam int CB  = 2 * COORD_BITS + 2;
  localparam int NB  = CB + 2 * FRAC_BITS;
  localparam int DB  = psd_pkg::DistBits;
  localparam int TB  = CB + 2;

  logic          g_vld;
  logic [RB-1:0] g_rad;
  logic [CB-1:0] g_cross;
  logic [1:0]    g_region;

  assign busy = 1'b0;

  psd_geom #(.FracBits(FRAC_BITS)) u_geom (
    .clk, .rst_n,
    .in_vld(start & ~busy), .in_req,
    .out_vld(g_vld), .out_rad(g_rad), .out_cross(g_cross), .out_region(g_region)
  );

  logic          s_vld;
  logic [QB-1:0] s_root;
  logic [TB-1:0] s_tag;

  psd_isqrt #(.InBits(RB), .TagBits(TB)) u_sqrt (
    .clk, .rst_n, .in_vld(g_vld), .in_rad(g_rad),
    .in_tag({g_region, g_cross}),
    .out_vld(s_vld), .out_root(s_root), .out_tag(s_tag)
  );

  logic          d_vld;
  logic [NB-1:0] d_quo;
  logic [TB+QB-1:0] d_tag;
  logic [NB-1:0] num_nxt;
  logic [QB-1:0] den_nxt;

  always_comb begin
    num_nxt = NB'(s_tag[CB-1:0]) << (2 * FRAC_BITS);
    den_nxt = (s_root == '0) ? QB'(1) : s_root;
  end

  psd_div #(.NumBits(NB), .DenBits(QB), .TagBits(TB + QB)) u_div (
    .clk, .rst_n, .in_vld(s_vld), .in_num(num_nxt), .in_den(den_nxt),
    .in_tag({s_tag, s_root}),
    .out_vld(d_vld), .out_quo(d_quo), .out_tag(d_tag)
  );

  logic [1:0]    f_region;
  logic [QB-1:0] f_root;
  logic [NB+QB-1:0] dist_nxt;
  logic          strobe_r;
  psd_pkg::out_res_t res_r;
  psd_pkg::out_res_t res_nxt;

  always_comb begin
    f_region = d_tag[TB+QB-1 -: 2];
    f_root   = d_tag[QB-1:0];
    case (f_region)
      psd_pkg::REG_DEGEN: dist_nxt = '0;
      psd_pkg::REG_INNER: dist_nxt = (NB+QB)'(d_quo);
      default:            dist_nxt = (NB+QB)'(f_root);
    endcase
    res_nxt.region   = f_region;
    res_nxt.distance = (dist_nxt > (NB+QB)'({DB{1'b1}})) ? {DB{1'b1}} : DB'(dist_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) strobe_r <= 1'b0;
    else strobe_r <= d_vld;
    res_r <= res_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_res    = res_r;

  a_busy_low: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_res.region == psd_pkg::REG_DEGEN |-> out_res.distance == '0)
    else $error("degenerate distance not zero");
  a_strobe_reset: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("strobe after reset");
endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int          StallLimit = 5000;
  localparam int          DrainWait  = 400;
  localparam logic [24:0] DistSat    = 25'h1ffffff;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  psd_pkg::in_req_t   in_req = '0;
  logic      out_strobe;
  psd_pkg::out_res_t  out_res;

  psd_pkg::in_req_t   pending_reqs[$];
  psd_pkg::out_res_t  expected_dists[$];
  int        mismatches = 0;
  int        gap_left = 0;
  bit        no_gaps = 1'b0;
  bit        took_req = 1'b0;
  int        quiet_cycles = 0;

  point_segment_distance dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_strobe(out_strobe), .out_res(out_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root, cand;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= n) root = cand;
    end
    return root;
  endfunction

  function automatic psd_pkg::out_res_t seg_distance(psd_pkg::in_req_t r);
    longint x, y, ux, uy, len2, dot, fx, fy, c;
    longint unsigned d, ac;
    psd_pkg::out_res_t res;
    x  = longint'(r.point_x) - longint'(r.start_x);
    y  = longint'(r.point_y) - longint'(r.start_y);
    ux = longint'(r.end_x) - longint'(r.start_x);
    uy = longint'(r.end_y) - longint'(r.start_y);
    len2 = ux * ux + uy * uy;
    dot  = x * ux + y * uy;
    if (len2 == 0) begin
      d = 0;
      res.region = psd_pkg::REG_DEGEN;
    end else if (dot <= 0) begin
      d = floor_sqrt(longint'(x * x + y * y) << 16);
      res.region = psd_pkg::REG_START;
    end else if (dot >= len2) begin
      fx = x - ux;
      fy = y - uy;
      d = floor_sqrt(longint'(fx * fx + fy * fy) << 16);
      res.region = psd_pkg::REG_END;
    end else begin
      c = x * uy - y * ux;
      ac = (c < 0) ? -c : c;
      d = (ac << 16) / floor_sqrt(len2 << 16);
      res.region = psd_pkg::REG_INNER;
    end
    res.distance = (d > DistSat) ? DistSat : d[24:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic add_req(int px, int py, int sx, int sy, int ex, int ey);
    psd_pkg::in_req_t r;
    r.point_x = 16'(px); r.point_y = 16'(py); r.start_x = 16'(sx);
    r.start_y = 16'(sy); r.end_x = 16'(ex);   r.end_y = 16'(ey);
    pending_reqs.push_back(r);
  endtask

  function automatic int rand_coord(int span);
    if (span == 0) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // driver: new request at the falling edge once the last one was taken
  always @(negedge clk) begin
    logic nxt_start;
    nxt_start = start;
    if (rst_n && !(start && !took_req)) begin
      if (gap_left > 0) begin
        gap_left--;
        nxt_start = 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_req <= pending_reqs.pop_front();
        nxt_start = 1'b1;
        if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
        gap_left = no_gaps ? 0 : $urandom_range(0, 6);
      end else begin
        nxt_start = 1'b0;
      end
    end
    start <= nxt_start;
  end

  // monitor and prediction
  always @(posedge clk) begin
    psd_pkg::out_res_t want;
    took_req <= rst_n && start && !busy;
    if (rst_n && out_strobe) begin
      if (expected_dists.size() == 0) begin
        report_mismatch("unexpected result, distance", out_res.distance, 0);
      end else begin
        want = expected_dists.pop_front();
        if (out_res.distance !== want.distance)
          report_mismatch("distance", out_res.distance, want.distance);
        if (out_res.region !== want.region)
          report_mismatch("region", out_res.region, want.region);
      end
    end
    if (rst_n && start && !busy) expected_dists.push_back(seg_distance(in_req));
  end

  // watchdog on cycles where no request and no result moves
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (pending_reqs.size() > 0 || expected_dists.size() > 0) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("point_segment_distance test failed");
        $finish;
      end
    end
  end

  initial begin
    int span;
    // corners, degenerate, boundary projections
    add_req(0, 0, 0, 0, 0, 0);
    add_req(-32768, -32768, 5, 5, 5, 5);
    add_req(-32768, -32768, 32767, 32767, 32767, 32767);
    add_req(32767, 32767, -32768, -32768, -32768, -32768);
    add_req(-32768, 32767, 32767, -32768, 32767, -32767);
    add_req(-32768, -32768, 32767, 32767, -32767, -32767);
    add_req(32767, -32768, -32768, 32767, 32767, 32767);
    add_req(0, 32767, -32768, 0, 32767, 0);
    add_req(0, -32768, -32768, 32767, 32767, 32767);
    add_req(0, 0, -32768, -32768, 32767, 32767);
    add_req(0, 5, 0, 0, 10, 0);
    add_req(0, 5, 0, 0, 10, 0);
    add_req(10, 5, 0, 0, 10, 0);
    add_req(-3, 4, 0, 0, 10, 0);
    add_req(13, -4, 0, 0, 10, 0);
    add_req(3, 7, 0, 0, 10, 10);
    add_req(-32768, 32767, -32768, -32768, 32767, 32767);
    add_req(1, 1, 0, 0, 1, 2);
    add_req(-1, -1, -1, -1, 0, 0);
    for (int i = 0; i < 1700; i++) begin
      case ($urandom_range(0, 4))
        0: span = 0;
        1: span = 20;
        2: span = 300;
        default: span = 32767;
      endcase
      if ($urandom_range(0, 19) == 0) begin
        int sx, sy;
        sx = rand_coord(span);
        sy = rand_coord(span);
        add_req(rand_coord(span), rand_coord(span), sx, sy, sx, sy);
      end else if (span == 0 || span == 32767) begin
        add_req(rand_coord(0), rand_coord(0), rand_coord(0),
                rand_coord(0), rand_coord(0), rand_coord(0));
      end else begin
        add_req(rand_coord(span), rand_coord(span), rand_coord(span),
                rand_coord(span), rand_coord(span), rand_coord(span));
      end
    end
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    wait (pending_reqs.size() == 0 && expected_dists.size() == 0 && !start);
    repeat (DrainWait) @(posedge clk);
    if (mismatches == 0 && expected_dists.size() == 0) begin
      $display("point_segment_distance test passed");
    end else begin
      $display("point_segment_distance test failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/psd_pkg.sv
sv/psd_isqrt.sv
sv/psd_div.sv
sv/psd_geom.sv
sv/point_segment_distance.sv
verif/tb_top.sv
